// ===== rtl/vdcf_pkg.sv =====
package vdcf_pkg;

	// descriptor word layout: eleven packed 2-bit attribute types
	localparam int WORD_W        = 22;
	localparam int ATTRS_IN_WORD = 11;
	localparam int TYPE_W        = 2;
	localparam int ATTR_W        = 4;
	localparam int KIND_W        = 2;

	// request modes
	localparam logic MODE_FULL   = 1'b0;
	localparam logic MODE_SINGLE = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TERM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CMD   = 2'd2;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// attribute type at index i, zero for fields past the top of the word
	function automatic logic [TYPE_W-1:0] field_of(logic [WORD_W-1:0] w, logic [ATTR_W-1:0] i);
		logic [TYPE_W-1:0] f;
		f = '0;
		for (int k = 0; k < ATTRS_IN_WORD; k++) begin
			if (i == ATTR_W'(k)) begin
				f = w[TYPE_W*k +: TYPE_W];
			end
		end
		return f;
	endfunction

endpackage

// ===== rtl/vdcf_front.sv =====
module vdcf_front #(
	parameter int NUM_ATTRS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          mode,
	input  logic [vdcf_pkg::WORD_W-1:0]   desc_word,
	input  logic [vdcf_pkg::ATTR_W-1:0]   attr_index,
	input  logic [vdcf_pkg::TYPE_W-1:0]   attr_type,
	output logic                          push,
	output logic [1+vdcf_pkg::ATTR_W+vdcf_pkg::TYPE_W+NUM_ATTRS+vdcf_pkg::WORD_W-1:0] push_data
);
	import vdcf_pkg::*;

	logic [WORD_W-1:0]    shadow_q;
	logic [NUM_ATTRS-1:0] chg_mask;
	logic                 full_diff;
	logic                 idx_ok;
	logic                 single_diff;

	always_comb begin
		for (int i = 0; i < NUM_ATTRS; i++) begin
			chg_mask[i] = field_of(desc_word, ATTR_W'(i)) != field_of(shadow_q, ATTR_W'(i));
		end
	end

	assign full_diff   = desc_word != shadow_q;
	assign idx_ok      = ({1'b0, attr_index} < (ATTR_W+1)'(NUM_ATTRS))
	                     && ({1'b0, attr_index} < (ATTR_W+1)'(ATTRS_IN_WORD));
	assign single_diff = idx_ok && (field_of(shadow_q, attr_index) != attr_type);

	assign push = accept && ((mode == MODE_FULL) ? full_diff : single_diff);
	assign push_data = {mode, attr_index, attr_type, chg_mask, desc_word};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '0;
		end else if (push) begin
			if (mode == MODE_FULL) begin
				shadow_q <= desc_word;
			end else begin
				for (int k = 0; k < ATTRS_IN_WORD; k++) begin
					if (attr_index == ATTR_W'(k)) begin
						shadow_q[TYPE_W*k +: TYPE_W] <= attr_type;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/vdcf_queue.sv =====
module vdcf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CW'(DEPTH);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/vdcf_back.sv =====
module vdcf_back #(
	parameter int NUM_ATTRS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [1+vdcf_pkg::ATTR_W+vdcf_pkg::TYPE_W+NUM_ATTRS+vdcf_pkg::WORD_W-1:0] q_head,
	output logic                          q_pop,
	output logic                          valid,
	output logic [vdcf_pkg::KIND_W-1:0]   kind,
	output logic [vdcf_pkg::ATTR_W-1:0]   out_attr,
	output logic [vdcf_pkg::TYPE_W-1:0]   out_type,
	output logic                          last
);
	import vdcf_pkg::*;

	back_state_t          state_q, state_d;
	logic                 single_q;
	logic [ATTR_W-1:0]    attr_q;
	logic [TYPE_W-1:0]    type_q;
	logic [NUM_ATTRS-1:0] mask_q;
	logic [WORD_W-1:0]    word_q;

	logic [ATTR_W-1:0]    low_idx;
	logic                 finish;
	logic                 load;
	logic                 step;
	logic                 valid_d;
	logic [KIND_W-1:0]    kind_d;
	logic [ATTR_W-1:0]    attr_d;
	logic [TYPE_W-1:0]    type_d;
	logic                 last_d;

	// lowest pending changed attribute
	always_comb begin
		low_idx = '0;
		for (int i = NUM_ATTRS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = ATTR_W'(i);
			end
		end
	end

	// result selection
	always_comb begin
		valid_d = 1'b0;
		kind_d  = KIND_ENTRY;
		attr_d  = '0;
		type_d  = '0;
		last_d  = 1'b0;
		finish  = 1'b0;
		step    = 1'b0;
		if (state_q == BK_EMIT) begin
			valid_d = 1'b1;
			if (single_q) begin
				kind_d = KIND_CMD;
				attr_d = attr_q;
				type_d = type_q;
				last_d = 1'b1;
				finish = 1'b1;
			end else if (mask_q != '0) begin
				kind_d = KIND_ENTRY;
				attr_d = low_idx;
				type_d = field_of(word_q, low_idx);
				step   = 1'b1;
			end else begin
				kind_d = KIND_TERM;
				last_d = 1'b1;
				finish = 1'b1;
			end
		end
	end

	assign load  = !q_empty && ((state_q == BK_IDLE) || finish);
	assign q_pop = load;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (load) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (finish) begin
					state_d = load ? BK_EMIT : BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid   <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		kind     <= kind_d;
		out_attr <= attr_d;
		out_type <= type_d;
		last     <= last_d;
		if (load) begin
			{single_q, attr_q, type_q, mask_q, word_q} <= q_head;
		end else if (step) begin
			mask_q <= mask_q & (mask_q - 1'b1);
		end
	end

endmodule

// ===== rtl/vertex_descriptor_change_filter.sv =====
// Vertex descriptor change filter. A request is taken when start is high and
// busy is low. A whole-word request that matches the shadow costs nothing; one
// that differs yields one entry per changed attribute in ascending order and
// then a terminator with last set, so it gives n+1 results in the result
// stage (n changed attributes, at most NUM_ATTRS+1 = 12 results). A single
// attribute request that changes the shadow yields one command; one that
// changes nothing, or names an attribute out of range, yields none.
// The result emitter, one result per cycle, sets the rate. Results appear on
// kind/out_attr/out_type/last for exactly one cycle with valid high and cannot
// be held off. Requests are classified and the shadow updated at once on
// acceptance; the jobs wait in a two-entry queue, and busy is high while
// that queue is full. The first result of a job passes through the queue,
// the emitter state register and the output registers.
module vertex_descriptor_change_filter #(
	parameter int NUM_ATTRS = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [vdcf_pkg::WORD_W-1:0]   desc_word,
	input  logic [vdcf_pkg::ATTR_W-1:0]   attr_index,
	input  logic [vdcf_pkg::TYPE_W-1:0]   attr_type,
	// result side
	output logic                          valid,
	output logic [vdcf_pkg::KIND_W-1:0]   kind,
	output logic [vdcf_pkg::ATTR_W-1:0]   out_attr,
	output logic [vdcf_pkg::TYPE_W-1:0]   out_type,
	output logic                          last
);
	import vdcf_pkg::*;

	// job: {single flag, attribute, type, changed mask, new word}
	localparam int JOB_W = 1 + ATTR_W + TYPE_W + NUM_ATTRS + WORD_W;
	localparam int QUEUE_DEPTH = 2;

	logic             accept;
	logic             job_push;
	logic [JOB_W-1:0] job_in;
	logic [JOB_W-1:0] job_head;
	logic             job_pop;
	logic             job_empty;
	logic             job_full;

	assign busy   = job_full;
	assign accept = start && !busy;

	// front: classify the request, update the shadow, queue the work
	vdcf_front #(
		.NUM_ATTRS(NUM_ATTRS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.desc_word  (desc_word),
		.attr_index (attr_index),
		.attr_type  (attr_type),
		.push       (job_push),
		.push_data  (job_in)
	);

	// decoupling queue between classification and emission
	vdcf_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.pop       (job_pop),
		.head      (job_head),
		.empty     (job_empty),
		.full      (job_full)
	);

	// back: walk the changed mask, one result per cycle
	vdcf_back #(
		.NUM_ATTRS(NUM_ATTRS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (job_empty),
		.q_head   (job_head),
		.q_pop    (job_pop),
		.valid    (valid),
		.kind     (kind),
		.out_attr (out_attr),
		.out_type (out_type),
		.last     (last)
	);

endmodule

// ===== rtl/vdcf_checker.sv =====
module vdcf_checker #(
	parameter int NUM_ATTRS = 11
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          valid,
	input logic [vdcf_pkg::KIND_W-1:0]   kind,
	input logic [vdcf_pkg::ATTR_W-1:0]   out_attr,
	input logic [vdcf_pkg::TYPE_W-1:0]   out_type,
	input logic                          last
);
	import vdcf_pkg::*;

	// terminator carries fixed fields and closes the list
	a_term_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_TERM |-> last && out_attr == '0 && out_type == '0)
		else $error("terminator fields wrong");

	// list entries never close a request, commands always do
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (kind != KIND_ENTRY)))
		else $error("last flag does not match kind");

	// entries of one list come in strictly ascending attribute order
	a_entry_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_ENTRY && $past(valid) && $past(kind) == KIND_ENTRY
		|-> out_attr > $past(out_attr))
		else $error("list entries out of order");

	// attributes reported are within range
	a_attr_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_ENTRY || kind == KIND_CMD)
		|-> ({1'b0, out_attr} < (ATTR_W+1)'(NUM_ATTRS)))
		else $error("attribute out of range");

endmodule

bind vertex_descriptor_change_filter vdcf_checker #(.NUM_ATTRS(NUM_ATTRS)) u_vdcf_checker (.*);
